// ===== src/sha_pkg.sv =====
// SHA-256 hasher package: round constants, initial hash values and round functions.
// Used by every module of the hasher; depends on nothing.
`timescale 1ns / 1ps
package sha_pkg;
    localparam int BlockWords = 16;
    localparam int Rounds = 64;
    localparam int FifoDepth = 4;

    typedef logic [31:0] word_t;

    // One request that the front part hands to the back part.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_message;
    } item_t;

    localparam logic [255:0] InitHash = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic word_t round_k(input logic [5:0] idx);
        word_t k;
        begin
            case (idx)
                6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
                6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
                6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
                6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
                6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
                6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
                6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
                6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
                6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
                6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
                6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
                6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
                6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
                6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
                6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
                6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
                6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
                6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
                6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
                6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
                6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
                default: k = 32'hc67178f2;
            endcase
            return k;
        end
    endfunction

    function automatic word_t rotr(input word_t x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic word_t sig0(input word_t x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t sig1(input word_t x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic word_t big_sig0(input word_t x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic word_t big_sig1(input word_t x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction
endpackage

// ===== src/sha_if.sv =====
// Valid/ready channel interfaces for the SHA-256 hasher.
// Depends on nothing beyond plain logic types.
`timescale 1ns / 1ps
interface sha_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
    modport source (output valid, data_byte, has_byte, end_of_message, input ready);
    modport sink (input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ===== src/sha_front.sv =====
// Front part of the SHA-256 hasher: takes requests, drops empty ones, queues the rest.
// Depends on sha_pkg and sha_if.
`timescale 1ns / 1ps
module sha_front #(
    parameter int DEPTH = sha_pkg::FifoDepth
) (
    input  logic                 clk,
    input  logic                 rst_n,
    sha_in_if.sink               in_ch,
    output logic                 q_valid,
    output sha_pkg::item_t       q_item,
    input  logic                 q_pop
);
    import sha_pkg::*;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    item_t mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]   count_reg;
    logic push;

    assign in_ch.ready = (count_reg != (AW+1)'(DEPTH));
    // A request that carries neither a byte nor an end changes nothing.
    assign push = in_ch.valid && in_ch.ready && (in_ch.has_byte || in_ch.end_of_message);
    assign q_valid = (count_reg != '0);
    assign q_item = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= '{in_ch.data_byte, in_ch.has_byte, in_ch.end_of_message};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (AW+1)'(push) - (AW+1)'(q_pop);
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == (AW+1)'(DEPTH) |-> !push) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid) else $error("queue underflow");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (AW+1)'(DEPTH)) else $error("queue count out of range");
`endif
endmodule

// ===== src/sha_back.sv =====
// Back part of the SHA-256 hasher: byte packing, padding, 64-round compression
// with a rolling 16-word schedule, and digest output. Depends on sha_pkg and sha_if.
`timescale 1ns / 1ps
module sha_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  sha_pkg::item_t q_item,
    output logic           q_pop,
    sha_out_if.source      out_ch
);
    import sha_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_PAD, S_LEN, S_COMP, S_FINAL, S_OUT
    } state_t;

    state_t state_reg;
    word_t  blk_reg [BlockWords];
    word_t  hash_reg [8];
    word_t  v_reg [8];
    logic [63:0] bit_count_reg, len_reg;
    logic [5:0]  pos_reg;
    logic [5:0]  round_reg;
    logic [2:0]  len_idx_reg;
    logic [1:0]  out_idx_reg;
    logic        fin_reg;
    logic        pad_pend_reg;
    logic        len_done_reg;
    logic [63:0] out_word_reg;

    // Byte to place this cycle and whether one is placed.
    logic       put;
    logic [7:0] put_byte;
    word_t      w_new, t1, t2;

    always_comb
    begin
        put = 1'b0;
        put_byte = 8'h00;
        unique case (state_reg)
            S_IDLE:
            begin
                put = q_valid && q_item.has_byte;
                put_byte = q_item.data_byte;
            end
            S_PAD:
            begin
                put = 1'b1;
                put_byte = (fin_reg) ? 8'h00 : 8'h80;
            end
            S_LEN:
            begin
                put = 1'b1;
                put_byte = len_reg[63:56];
            end
            default:
            begin
                put = 1'b0;
            end
        endcase
    end

    // Rolling schedule: blk_reg[0] is W[t]; the next word enters at the top.
    assign w_new = blk_reg[0] + sig0(blk_reg[1]) + blk_reg[9] + sig1(blk_reg[14]);
    assign t1 = v_reg[7] + big_sig1(v_reg[4]) + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
        + round_k(round_reg) + blk_reg[0];
    assign t2 = big_sig0(v_reg[0])
        + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));

    assign q_pop = (state_reg == S_IDLE) && q_valid;
    assign out_ch.valid = (state_reg == S_OUT);
    assign out_ch.digest_word = out_word_reg;
    assign out_ch.word_index = out_idx_reg;
    assign out_ch.last_word = (out_idx_reg == 2'd3);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            for (int i = 0; i < 8; i++)
            begin
                hash_reg[i] <= InitHash[255 - 32*i -: 32];
                v_reg[i] <= '0;
            end
            for (int i = 0; i < BlockWords; i++)
            begin
                blk_reg[i] <= '0;
            end
            bit_count_reg <= '0;
            len_reg <= '0;
            pos_reg <= '0;
            round_reg <= '0;
            len_idx_reg <= '0;
            out_idx_reg <= '0;
            fin_reg <= 1'b0;
            pad_pend_reg <= 1'b0;
            len_done_reg <= 1'b0;
            out_word_reg <= '0;
        end
        else
        begin
            if (put)
            begin
                blk_reg[pos_reg[5:2]][8*(3 - 32'(pos_reg[1:0])) +: 8] <= put_byte;
                pos_reg <= pos_reg + 1'b1;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        if (q_item.has_byte)
                        begin
                            bit_count_reg <= bit_count_reg + 64'd8;
                        end
                        if (q_item.end_of_message)
                        begin
                            len_reg <= bit_count_reg + (q_item.has_byte ? 64'd8 : 64'd0);
                            fin_reg <= 1'b0;
                            pad_pend_reg <= 1'b1;
                            state_reg <= S_PAD;
                        end
                        // A full block is compressed first; padding follows if an end waits.
                        if (q_item.has_byte && pos_reg == 6'd63)
                        begin
                            state_reg <= S_COMP;
                        end
                        if (q_item.has_byte && pos_reg == 6'd63 || q_item.end_of_message)
                        begin
                            for (int i = 0; i < 8; i++)
                            begin
                                v_reg[i] <= hash_reg[i];
                            end
                            round_reg <= '0;
                        end
                    end
                end
                S_PAD:
                begin
                    // fin_reg marks that the 0x80 byte has gone in.
                    fin_reg <= 1'b1;
                    if (pos_reg == 6'd63)
                    begin
                        state_reg <= S_COMP;
                    end
                    else if (pos_reg == 6'd55)
                    begin
                        len_idx_reg <= '0;
                        state_reg <= S_LEN;
                    end
                    for (int i = 0; i < 8; i++)
                    begin
                        v_reg[i] <= hash_reg[i];
                    end
                    round_reg <= '0;
                end
                S_LEN:
                begin
                    len_reg <= {len_reg[55:0], 8'h00};
                    len_idx_reg <= len_idx_reg + 1'b1;
                    if (len_idx_reg == 3'd7)
                    begin
                        fin_reg <= 1'b0;
                        pad_pend_reg <= 1'b0;
                        len_done_reg <= 1'b1;
                        state_reg <= S_COMP;
                    end
                end
                S_COMP:
                begin
                    for (int i = 0; i < BlockWords - 1; i++)
                    begin
                        blk_reg[i] <= blk_reg[i + 1];
                    end
                    blk_reg[BlockWords - 1] <= w_new;
                    v_reg[7] <= v_reg[6];
                    v_reg[6] <= v_reg[5];
                    v_reg[5] <= v_reg[4];
                    v_reg[4] <= v_reg[3] + t1;
                    v_reg[3] <= v_reg[2];
                    v_reg[2] <= v_reg[1];
                    v_reg[1] <= v_reg[0];
                    v_reg[0] <= t1 + t2;
                    round_reg <= round_reg + 1'b1;
                    if (round_reg == 6'(Rounds - 1))
                    begin
                        state_reg <= S_FINAL;
                    end
                end
                S_FINAL:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        hash_reg[i] <= hash_reg[i] + v_reg[i];
                    end
                    out_word_reg <= {hash_reg[0] + v_reg[0], hash_reg[1] + v_reg[1]};
                    out_idx_reg <= '0;
                    if (len_done_reg)
                    begin
                        len_done_reg <= 1'b0;
                        state_reg <= S_OUT;
                    end
                    else if (pad_pend_reg)
                    begin
                        // The message has ended; padding goes on in a fresh block.
                        state_reg <= S_PAD;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_OUT:
                begin
                    if (out_ch.ready)
                    begin
                        out_idx_reg <= out_idx_reg + 1'b1;
                        out_word_reg <= {hash_reg[{out_idx_reg + 2'd1, 1'b0}],
                                         hash_reg[{out_idx_reg + 2'd1, 1'b1}]};
                        if (out_idx_reg == 2'd3)
                        begin
                            for (int i = 0; i < 8; i++)
                            begin
                                hash_reg[i] <= InitHash[255 - 32*i -: 32];
                            end
                            bit_count_reg <= '0;
                            len_idx_reg <= '0;
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_out_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.last_word |-> out_idx_reg == 2'd3)
        else $error("last word flag off index");
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> state_reg == S_IDLE) else $error("pop outside idle");
    a_len_pos: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_LEN |-> pos_reg[5:3] == 3'd7) else $error("length bytes misplaced");
    a_out_reset: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.ready && out_ch.last_word |=> bit_count_reg == 64'd0)
        else $error("bit count not cleared");
`endif
endmodule

// ===== src/sha256_hasher_top.sv =====
// Streaming SHA-256 hasher top level: request queue front part and compression back part.
// Once the back part takes an end request, it pads the message one byte a cycle and runs
// one or two compressions of the round unit before the first digest word is valid.
// Throughput: one byte per cycle in the idle state, one compression per 64-byte block;
// input stalls once the four-entry queue fills while rounds run or digest words wait.
// Reset is asynchronous, active low; it loads the initial hash and clears the counts.
`timescale 1ns / 1ps
module sha256_hasher_top #(
    parameter int FIFO_DEPTH = sha_pkg::FifoDepth
) (
    input logic        clk,
    input logic        rst_n,
    sha_in_if.sink     in_ch,
    sha_out_if.source  out_ch
);
    import sha_pkg::*;

    logic  q_valid, q_pop;
    item_t q_item;

    sha_front #(.DEPTH(FIFO_DEPTH)) u_front (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
        .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
    );

    sha_back u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop), .out_ch(out_ch)
    );
endmodule
